// ===== src/cpob_pkg.sv =====
package cpob_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned BoxBits = 36;
  localparam int unsigned SqBits = 35;
  localparam int unsigned RootBits = 18;

  localparam logic [CfgIdxBits-1:0] RegInvX = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegInvY = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegInvZ = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegFwdX = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegFwdY = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegFwdZ = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegHalf = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegMode = 3'd7;

  localparam logic [63:0] RowXReset = 64'd16384;
  localparam logic [63:0] RowYReset = 64'd16384 << 16;
  localparam logic [63:0] RowZReset = 64'd16384 << 32;

  typedef logic signed [CoordBits-1:0] coord_t;

endpackage

// ===== src/closest_point_on_oriented_box.sv =====
// Closest point on an oriented box with Euclidean distance.
// Stages in order: affine stages, distance stages, root stages, rounding.
// Throughput: one query per cycle unless stalled; the square root runs as
// nine pipelined two-bit stages. A stall on the output freezes the whole
// pipeline.
// Reset: asynchronous, active low; clears valid bits and loads identity rows,
// zero half sizes and box mode.
module closest_point_on_oriented_box (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cpob_pkg::CoordBits-1:0] query_x_i,
  input  logic signed [cpob_pkg::CoordBits-1:0] query_y_i,
  input  logic signed [cpob_pkg::CoordBits-1:0] query_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cpob_pkg::CoordBits-1:0] near_x_o,
  output logic signed [cpob_pkg::CoordBits-1:0] near_y_o,
  output logic signed [cpob_pkg::CoordBits-1:0] near_z_o,
  output logic [15:0]                         gap_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cpob_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [cpob_pkg::CfgDataBits-1:0]    cfg_data_i
);

  localparam int unsigned CB = cpob_pkg::CoordBits;
  localparam int unsigned BB = cpob_pkg::BoxBits;
  localparam int unsigned SB = cpob_pkg::SqBits;
  localparam int unsigned RB = cpob_pkg::RootBits;
  localparam int unsigned NSq = RB / 2;
  localparam int unsigned PB = BB + 16;
  localparam int unsigned AB = PB + 2;

  logic [63:0] inv_q [3];
  logic [63:0] fwd_q [3];
  logic [47:0] half_q;
  logic        mode_q;
  logic        adv;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_stall_i;
  assign in_stall_o  = out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q[0] <= cpob_pkg::RowXReset;
      inv_q[1] <= cpob_pkg::RowYReset;
      inv_q[2] <= cpob_pkg::RowZReset;
      fwd_q[0] <= cpob_pkg::RowXReset;
      fwd_q[1] <= cpob_pkg::RowYReset;
      fwd_q[2] <= cpob_pkg::RowZReset;
      half_q   <= '0;
      mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cpob_pkg::RegInvX: inv_q[0] <= cfg_data_i;
        cpob_pkg::RegInvY: inv_q[1] <= cfg_data_i;
        cpob_pkg::RegInvZ: inv_q[2] <= cfg_data_i;
        cpob_pkg::RegFwdX: fwd_q[0] <= cfg_data_i;
        cpob_pkg::RegFwdY: fwd_q[1] <= cfg_data_i;
        cpob_pkg::RegFwdZ: fwd_q[2] <= cfg_data_i;
        cpob_pkg::RegHalf: half_q   <= cfg_data_i[47:0];
        cpob_pkg::RegMode: mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // valid shift line, one bit per stage
  localparam int unsigned NStg = 8 + NSq;
  logic [NStg-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NStg-2:0], in_valid_i};
  end

  // query delay line
  logic signed [CB-1:0] qd_q [NStg][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      qd_q[0][0] <= query_x_i;
      qd_q[0][1] <= query_y_i;
      qd_q[0][2] <= query_z_i;
      for (int s = 1; s < NStg; s++) qd_q[s] <= qd_q[s-1];
    end
  end

  // stage 1: inverse products
  logic signed [CB+15:0] ip_q [3][4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++)
          ip_q[r][c] <= (CB+16)'($signed(inv_q[r][16*c +: 16])) * qd_q[0][c];
        ip_q[r][3] <= (CB+16)'($signed({inv_q[r][63:48], 14'd0}));
      end
    end
  end

  // stage 2: sum, round, clamp
  logic signed [BB-1:0] box_q [3];
  always_ff @(posedge clk_i) begin
    logic signed [CB+18:0] acc;
    logic signed [BB-1:0] v, h;
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        acc = (CB+19)'(ip_q[r][0]) + (CB+19)'(ip_q[r][1]) + (CB+19)'(ip_q[r][2])
            + (CB+19)'(ip_q[r][3]) + (CB+19)'(8192);
        v = BB'(acc >>> 14);
        h = BB'({1'b0, half_q[16*r +: 16]});
        if (v < -h) v = -h;
        if (v > h) v = h;
        box_q[r] <= v;
      end
    end
  end

  // stage 3: forward products
  logic signed [PB-1:0] fp_q [3][4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++)
          fp_q[r][c] <= PB'($signed(fwd_q[r][16*c +: 16]) * box_q[c]);
        fp_q[r][3] <= PB'($signed({fwd_q[r][63:48], 14'd0}));
      end
    end
  end

  // stage 4: sum, round, saturate, select mode
  logic signed [CB-1:0] res_q [3];
  always_ff @(posedge clk_i) begin
    logic signed [AB-1:0] acc;
    logic signed [AB-15:0] w, p;
    localparam logic signed [AB-15:0] Hi = (AB-14)'((64'sd1 <<< (CB-1)) - 1);
    localparam logic signed [AB-15:0] Lo = -Hi - 1;
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        acc = AB'(fp_q[r][0]) + AB'(fp_q[r][1]) + AB'(fp_q[r][2])
            + AB'(fp_q[r][3]) + AB'(8192);
        w = (AB-14)'(acc >>> 14);
        p = (AB-14)'($signed(fwd_q[r][63:48]));
        if (mode_q) w = p;
        res_q[r] <= (w > Hi) ? CB'(Hi) : ((w < Lo) ? CB'(Lo) : CB'(w));
      end
    end
  end

  // stage 5: differences
  logic [16:0] ad_q [3];
  logic        big_q;
  always_ff @(posedge clk_i) begin
    logic signed [CB:0] d;
    logic [CB:0] a;
    logic b;
    if (adv) begin
      b = 1'b0;
      for (int r = 0; r < 3; r++) begin
        d = (CB+1)'(res_q[r]) - (CB+1)'(qd_q[4][r]);
        a = d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
        if (a > (CB+1)'(65535)) b = 1'b1;
        ad_q[r] <= 17'(a);
      end
      big_q <= b;
    end
  end

  // stage 6: squares and sum
  logic [SB-1:0] sum_q;
  logic          bigs_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= SB'(ad_q[0]) * SB'(ad_q[0]) + SB'(ad_q[1]) * SB'(ad_q[1])
             + SB'(ad_q[2]) * SB'(ad_q[2]);
      bigs_q <= big_q;
    end
  end

  // square root: two result bits per stage
  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    logic [SB-1:0] rs_q;
    logic [RB-1:0] rr_q;
    logic          rb_q;
    logic [SB-1:0] s_in;
    logic [RB-1:0] r_in;
    logic          b_in;
    if (k == 0) begin : g_src
      assign s_in = sum_q;
      assign r_in = '0;
      assign b_in = bigs_q;
    end else begin : g_src
      assign s_in = g_sqrt[k-1].rs_q;
      assign r_in = g_sqrt[k-1].rr_q;
      assign b_in = g_sqrt[k-1].rb_q;
    end
    always_ff @(posedge clk_i) begin
      logic [SB+1:0] tr, rem;
      logic [RB-1:0] r1;
      if (adv) begin
        rem = (SB+2)'(s_in);
        r1 = r_in;
        for (int j = 0; j < 2; j++) begin
          tr = (SB+2)'({r1, 2'b01}) << (2 * (RB - 1 - 2 * k - j));
          r1 = r1 << 1;
          if (rem >= tr) begin
            rem = rem - tr;
            r1 = r1 | RB'(1);
          end
        end
        rs_q <= SB'(rem);
        rr_q <= r1;
        rb_q <= b_in;
      end
    end
  end

  // final: round and saturate
  logic [15:0] gap_q;
  always_ff @(posedge clk_i) begin
    logic [RB:0] g;
    if (adv) begin
      g = (RB+1)'(g_sqrt[NSq-1].rr_q);
      if (g_sqrt[NSq-1].rs_q > SB'(g_sqrt[NSq-1].rr_q)) g = g + (RB+1)'(1);
      gap_q <= (g_sqrt[NSq-1].rb_q || g > (RB+1)'(65535)) ? 16'hFFFF : g[15:0];
    end
  end

  // result coordinates delayed to line up with gap
  localparam int unsigned RD = NSq + 3;
  logic signed [CB-1:0] rd_q [RD][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q[0] <= res_q;
      for (int s = 1; s < RD; s++) rd_q[s] <= rd_q[s-1];
    end
  end

  assign out_valid_o = v_q[NStg-1];
  assign near_x_o    = rd_q[RD-1][0];
  assign near_y_o    = rd_q[RD-1][1];
  assign near_z_o    = rd_q[RD-1][2];
  assign gap_o       = gap_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gap_o) && $stable(near_x_o))
    else $error("result changed under stall");
  a_in_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == out_stall_i) else $error("input stall out of step");
  a_zero_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gap_o == 16'd0 |-> near_x_o == qd_q[NStg-1][0]
      && near_y_o == qd_q[NStg-1][1] && near_z_o == qd_q[NStg-1][2])
    else $error("zero gap away from query");

endmodule

// ===== tb/closest_point_on_oriented_box_tb.sv =====
module closest_point_on_oriented_box_tb;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [15:0] gap;
  } near_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cpob_pkg::coord_t qx = '0, qy = '0, qz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cpob_pkg::coord_t nx, ny, nz;
  logic [15:0] gap;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cpob_pkg::CfgIdxBits-1:0] cfg_index = '0;
  logic [cpob_pkg::CfgDataBits-1:0] cfg_data = '0;

  logic [63:0] m_inv [3];
  logic [63:0] m_fwd [3];
  logic [47:0] m_half;
  logic m_point;

  near_pt_t near_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  int hold_pct = 30;
  int sender_gap_pct = 30;

  closest_point_on_oriented_box i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .query_x_i(qx), .query_y_i(qy), .query_z_i(qz),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .near_x_o(nx), .near_y_o(ny), .near_z_o(nz), .gap_o(gap),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint row_apply(logic [63:0] row, longint p0, longint p1, longint p2);
    longint acc;
    acc = longint'($signed(row[15:0])) * p0 + longint'($signed(row[31:16])) * p1
        + longint'($signed(row[47:32])) * p2 + longint'($signed(row[63:48])) * 16384;
    return (acc + 8192) >>> 14;
  endfunction

  function automatic longint sat16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic near_pt_t closest_point(cpob_pkg::coord_t x, cpob_pkg::coord_t y,
                                             cpob_pkg::coord_t z);
    longint q[3], b[3], r[3], h, d, s, g;
    logic big;
    near_pt_t o;
    q[0] = x; q[1] = y; q[2] = z;
    big = 1'b0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if (m_point) begin
        r[i] = longint'($signed(m_fwd[i][63:48]));
      end else begin
        h = m_half[16*i +: 16];
        b[i] = row_apply(m_inv[i], q[0], q[1], q[2]);
        if (b[i] < -h) b[i] = -h;
        if (b[i] > h) b[i] = h;
      end
    end
    if (!m_point)
      for (int i = 0; i < 3; i++) r[i] = sat16(row_apply(m_fwd[i], b[0], b[1], b[2]));
    for (int i = 0; i < 3; i++) begin
      d = r[i] - q[i];
      if (d < 0) d = -d;
      if (d > 65535) big = 1'b1;
      else s += d * d;
    end
    if (big) begin
      g = 65535;
    end else begin
      g = 0;
      for (int k = 17; k >= 0; k--)
        if ((g + (64'd1 << k)) * (g + (64'd1 << k)) <= s) g += 64'd1 << k;
      if (s - g * g > g) g++;
      if (g > 65535) g = 65535;
    end
    o.px = r[0][15:0]; o.py = r[1][15:0]; o.pz = r[2][15:0]; o.gap = g[15:0];
    return o;
  endfunction

  task automatic write_reg(logic [cpob_pkg::CfgIdxBits-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cpob_pkg::RegInvX: m_inv[0] = val;
      cpob_pkg::RegInvY: m_inv[1] = val;
      cpob_pkg::RegInvZ: m_inv[2] = val;
      cpob_pkg::RegFwdX: m_fwd[0] = val;
      cpob_pkg::RegFwdY: m_fwd[1] = val;
      cpob_pkg::RegFwdZ: m_fwd[2] = val;
      cpob_pkg::RegHalf: m_half = val[47:0];
      cpob_pkg::RegMode: m_point = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_query(cpob_pkg::coord_t x, cpob_pkg::coord_t y, cpob_pkg::coord_t z);
    if ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(9) == 0 ? $urandom_range(40, 10) : $urandom_range(3, 1))
        @(posedge clk);
    end
    in_valid <= 1'b1;
    qx <= x; qy <= y; qz <= z;
    do @(posedge clk); while (in_stall);
    near_q = {near_q, closest_point(x, y, z)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (near_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_row();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(1)) begin
      r[15:0] = 16'($urandom_range(32767) - 16384);
      r[31:16] = 16'($urandom_range(32767) - 16384);
      r[47:32] = 16'($urandom_range(32767) - 16384);
      r[63:48] = 16'($urandom_range(8191) - 4096);
    end
    return r;
  endfunction

  task automatic set_box(logic [63:0] iv [3], logic [63:0] fw [3], logic [47:0] hf);
    write_reg(cpob_pkg::RegInvX, iv[0]);
    write_reg(cpob_pkg::RegInvY, iv[1]);
    write_reg(cpob_pkg::RegInvZ, iv[2]);
    write_reg(cpob_pkg::RegFwdX, fw[0]);
    write_reg(cpob_pkg::RegFwdY, fw[1]);
    write_reg(cpob_pkg::RegFwdZ, fw[2]);
    write_reg(cpob_pkg::RegHalf, {16'd0, hf});
  endtask

  task automatic random_queries(int n);
    for (int i = 0; i < n; i++)
      send_query(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    logic [63:0] iv [3], fw [3];
    send_query(16'sh7fff, -16'sh8000, 16'sd0);
    send_query(16'sd0, 16'sd0, 16'sd0);
    send_query(16'sd1, 16'sd0, 16'sd0);
    drain();
    iv[0] = cpob_pkg::RowXReset; iv[1] = cpob_pkg::RowYReset; iv[2] = cpob_pkg::RowZReset;
    fw[0] = cpob_pkg::RowXReset | (64'h0100 << 48);
    fw[1] = cpob_pkg::RowYReset | (64'hff00 << 48);
    fw[2] = cpob_pkg::RowZReset;
    set_box(iv, fw, {16'h0200, 16'h0100, 16'h0080});
    send_query(16'sd0, 16'sd0, 16'sd0);
    send_query(16'sh0100, -16'sh0100, 16'sd0);
    send_query(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_query(-16'sh8000, -16'sh8000, -16'sh8000);
    send_query(16'sh0150, -16'sh00f0, 16'sh0010);
    drain();
    set_box(iv, fw, 48'hffff_ffff_ffff);
    send_query(16'sh7fff, -16'sh8000, 16'sh7fff);
    send_query(-16'sh8000, 16'sh7fff, -16'sh8000);
    drain();
    write_reg(cpob_pkg::RegMode, 64'd1);
    send_query(16'sd0, 16'sd0, 16'sd0);
    send_query(-16'sh8000, -16'sh8000, 16'sh7fff);
    send_query(16'sh0100, -16'sh0100, 16'sd0);
    drain();
    write_reg(cpob_pkg::RegMode, 64'd0);
  endtask

  task automatic test_random_boxes();
    logic [63:0] iv [3], fw [3];
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < 3; i++) begin
        iv[i] = rand_row();
        fw[i] = rand_row();
      end
      set_box(iv, fw, ph == 0 ? 48'hffff_ffff_ffff : (ph == 1 ? 48'd0 :
        48'({$urandom, $urandom} & 64'h7fff_7fff_7fff)));
      write_reg(cpob_pkg::RegMode, 64'(ph % 4 == 3));
      hold_pct = (ph % 3 == 0) ? 0 : 35;
      sender_gap_pct = (ph % 3 == 1) ? 0 : 30;
      random_queries(160);
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_pct = 0;
    sender_gap_pct = 0;
    write_reg(cpob_pkg::RegMode, 64'd0);
    fork
      random_queries(60);
      begin
        @(posedge clk);
        hold_cycles = 80;
      end
    join
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < hold_pct);
    end
  end

  always @(posedge clk) begin
    near_pt_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (near_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %h", $time, nx, ny, nz, gap);
        errors++;
      end else begin
        e = near_q.pop_front();
        if (e.px != nx) begin
          $display("%0t: near_x exp %h got %h", $time, e.px, nx); errors++;
        end
        if (e.py != ny) begin
          $display("%0t: near_y exp %h got %h", $time, e.py, ny); errors++;
        end
        if (e.pz != nz) begin
          $display("%0t: near_z exp %h got %h", $time, e.pz, nz); errors++;
        end
        if (e.gap != gap) begin
          $display("%0t: gap exp %h got %h", $time, e.gap, gap); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL closest_point_on_oriented_box");
      $finish;
    end
  end

  initial begin
    m_inv[0] = cpob_pkg::RowXReset; m_inv[1] = cpob_pkg::RowYReset;
    m_inv[2] = cpob_pkg::RowZReset;
    m_fwd[0] = cpob_pkg::RowXReset; m_fwd[1] = cpob_pkg::RowYReset;
    m_fwd[2] = cpob_pkg::RowZReset;
    m_half = '0;
    m_point = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_boxes();
    test_backpressure();
    if (errors == 0) begin
      $display("PASS closest_point_on_oriented_box");
    end else begin
      $display("FAIL closest_point_on_oriented_box");
    end
    $finish;
  end

endmodule
